[rtl/core/ptsel_pkg.sv]
package ptsel_pkg;

	localparam int PAN_W      = 15;
	localparam int TILT_W     = 14;
	localparam int DIST_W     = 30;
	localparam int SQ_PAN_W   = 30;
	localparam int SQ_TILT_W  = 28;
	localparam int SCAN_IDX_W = 3;
	localparam int CMD_W      = 2;
	localparam int MODE_W     = 2;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_POSE   = 2'd0,
		CMD_TARGET = 2'd1,
		CMD_EMPTY  = 2'd2
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_PATROL = 2'd0,
		MODE_SEEK   = 2'd1,
		MODE_FOLLOW = 2'd2
	} mode_t;

	// register index, taken from paddr[2]
	localparam logic REG_MODE = 1'b0;

	localparam logic [SCAN_IDX_W-1:0] SCAN_START = 3'd2;
	localparam logic [SCAN_IDX_W-1:0] SCAN_LAST  = 3'd4;

	// scan positions, degrees x 64
	function automatic logic signed [PAN_W-1:0] scan_pan(input logic [SCAN_IDX_W-1:0] idx);
		logic signed [PAN_W-1:0] p;
		case (idx)
			3'd1:    p = 15'sd3200;
			3'd2:    p = 15'sd1600;
			3'd3:    p = 15'sd0;
			3'd4:    p = 15'sd3200;
			default: p = 15'sd0;
		endcase
		return p;
	endfunction

	function automatic logic signed [TILT_W-1:0] scan_tilt(input logic [SCAN_IDX_W-1:0] idx);
		logic signed [TILT_W-1:0] t;
		case (idx)
			3'd1:    t = -14'sd1280;
			3'd2:    t = -14'sd2240;
			3'd3:    t = -14'sd3200;
			3'd4:    t = -14'sd3200;
			default: t = -14'sd1280;
		endcase
		return t;
	endfunction

	function automatic logic [SCAN_IDX_W-1:0] scan_next(input logic [SCAN_IDX_W-1:0] idx);
		logic [SCAN_IDX_W-1:0] n;
		if (idx >= SCAN_LAST) begin
			n = '0;
		end else begin
			n = idx + 3'd1;
		end
		return n;
	endfunction

endpackage

[rtl/core/pan_tilt_scan_track_selector.sv]
// Pan/tilt aim selector. Takes one transaction per cycle on the item channel
// (pose update, frame target or empty frame) and gives at most one aim per
// transaction, offered once it has left both stages: stage one squares the pan
// and tilt offsets from the current pose, stage two adds them, compares against
// the running best of the open frame and picks the aim, and the aim waits in an
// output register. Sustained rate is one transaction per cycle; the input side
// only stalls when an aim waits untaken in the output register, the transaction
// in stage two would produce another and stage one is occupied. The user must
// write the mode register (APB address 0) only while the block is idle;
// the block does not enforce this. Mode 3 acts as follow mode.
module pan_tilt_scan_track_selector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ptsel_pkg::PADDR_W-1:0]        paddr,
	input  logic [ptsel_pkg::PDATA_W-1:0]        pwdata,
	output logic [ptsel_pkg::PDATA_W-1:0]        prdata,
	output logic                                 pready,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic [ptsel_pkg::CMD_W-1:0]          command,
	input  logic signed [ptsel_pkg::PAN_W-1:0]   pan,
	input  logic signed [ptsel_pkg::TILT_W-1:0]  tilt,
	input  logic                                 last,
	output logic                                 aim_valid,
	input  logic                                 aim_ready,
	output logic signed [ptsel_pkg::PAN_W-1:0]   aim_pan,
	output logic signed [ptsel_pkg::TILT_W-1:0]  aim_tilt,
	output logic                                 source
);

	logic [ptsel_pkg::MODE_W-1:0]         mode_q;
	logic signed [ptsel_pkg::PAN_W-1:0]   cur_pan_q;
	logic signed [ptsel_pkg::TILT_W-1:0]  cur_tilt_q;
	logic [ptsel_pkg::SCAN_IDX_W-1:0]     scan_idx_q;
	logic signed [ptsel_pkg::PAN_W-1:0]   best_pan_q;
	logic signed [ptsel_pkg::TILT_W-1:0]  best_tilt_q;
	logic [ptsel_pkg::DIST_W-1:0]         best_dist_q;
	logic                                 has_best_q;

	logic                                 v_s1;
	logic [ptsel_pkg::CMD_W-1:0]          cmd_s1;
	logic signed [ptsel_pkg::PAN_W-1:0]   pan_s1;
	logic signed [ptsel_pkg::TILT_W-1:0]  tilt_s1;
	logic                                 last_s1;

	logic                                 v_s2;
	logic [ptsel_pkg::CMD_W-1:0]          cmd_s2;
	logic signed [ptsel_pkg::PAN_W-1:0]   pan_s2;
	logic signed [ptsel_pkg::TILT_W-1:0]  tilt_s2;
	logic                                 last_s2;
	logic [ptsel_pkg::SQ_PAN_W-1:0]       sqp_s2;
	logic [ptsel_pkg::SQ_TILT_W-1:0]      sqt_s2;

	logic                                 aim_valid_q;
	logic signed [ptsel_pkg::PAN_W-1:0]   aim_pan_q;
	logic signed [ptsel_pkg::TILT_W-1:0]  aim_tilt_q;
	logic                                 source_q;

	logic                                 cfg_wr;
	logic                                 out_free;
	logic                                 go_s1;
	logic                                 go_s2;
	logic                                 free_s1;
	logic                                 free_s2;
	logic                                 accept;

	logic signed [ptsel_pkg::PAN_W:0]     dp_s1;
	logic signed [ptsel_pkg::TILT_W:0]    dt_s1;
	logic signed [31:0]                   prodp_s1;
	logic signed [29:0]                   prodt_s1;

	logic [ptsel_pkg::DIST_W:0]           dsum_s2;
	logic [ptsel_pkg::DIST_W-1:0]         dist_s2;
	logic                                 better_s2;
	logic signed [ptsel_pkg::PAN_W-1:0]   sel_pan_s2;
	logic signed [ptsel_pkg::TILT_W-1:0]  sel_tilt_s2;
	logic                                 scan_ok_s2;
	logic                                 emit_s2;
	logic                                 emit_scan_s2;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == ptsel_pkg::REG_MODE);

	always_comb begin
		prdata = '0;
		if (paddr[2] == ptsel_pkg::REG_MODE) begin
			prdata[ptsel_pkg::MODE_W-1:0] = mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ptsel_pkg::MODE_SEEK;
		end else if (cfg_wr) begin
			mode_q <= pwdata[ptsel_pkg::MODE_W-1:0];
		end
	end

	// flow control
	assign out_free   = ~aim_valid_q | aim_ready;
	assign go_s2      = v_s2 & (~emit_s2 | out_free);
	assign free_s2    = ~v_s2 | go_s2;
	assign go_s1      = v_s1 & free_s2;
	assign free_s1    = ~v_s1 | go_s1;
	assign item_ready = free_s1;
	assign accept     = item_valid & free_s1;

	// stage 1: offsets from current pose, squared
	assign dp_s1    = {cur_pan_q[ptsel_pkg::PAN_W-1], cur_pan_q}
	                - {pan_s1[ptsel_pkg::PAN_W-1], pan_s1};
	assign dt_s1    = {cur_tilt_q[ptsel_pkg::TILT_W-1], cur_tilt_q}
	                - {tilt_s1[ptsel_pkg::TILT_W-1], tilt_s1};
	assign prodp_s1 = dp_s1 * dp_s1;
	assign prodt_s1 = dt_s1 * dt_s1;

	// stage 2: distance, running best, aim selection
	assign dsum_s2     = {1'b0, sqp_s2} + {3'b000, sqt_s2};
	assign dist_s2     = dsum_s2[ptsel_pkg::DIST_W] ? '1 : dsum_s2[ptsel_pkg::DIST_W-1:0];
	assign better_s2   = ~has_best_q | (dist_s2 < best_dist_q);
	assign sel_pan_s2  = better_s2 ? pan_s2 : best_pan_q;
	assign sel_tilt_s2 = better_s2 ? tilt_s2 : best_tilt_q;
	assign scan_ok_s2  = (mode_q == ptsel_pkg::MODE_PATROL) | (mode_q == ptsel_pkg::MODE_SEEK);

	always_comb begin
		case (cmd_s2)
			ptsel_pkg::CMD_EMPTY: begin
				emit_s2      = scan_ok_s2;
				emit_scan_s2 = scan_ok_s2;
			end
			ptsel_pkg::CMD_TARGET: begin
				emit_s2      = last_s2;
				emit_scan_s2 = last_s2 & (mode_q == ptsel_pkg::MODE_PATROL);
			end
			default: begin
				emit_s2      = 1'b0;
				emit_scan_s2 = 1'b0;
			end
		endcase
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			pan_s1  <= pan;
			tilt_s1 <= tilt;
			last_s1 <= last;
		end
		if (go_s1) begin
			cmd_s2  <= cmd_s1;
			pan_s2  <= pan_s1;
			tilt_s2 <= tilt_s1;
			last_s2 <= last_s1;
			sqp_s2  <= prodp_s1[ptsel_pkg::SQ_PAN_W-1:0];
			sqt_s2  <= prodt_s1[ptsel_pkg::SQ_TILT_W-1:0];
		end
		if (go_s2 && emit_s2) begin
			aim_pan_q  <= emit_scan_s2 ? ptsel_pkg::scan_pan(scan_idx_q) : sel_pan_s2;
			aim_tilt_q <= emit_scan_s2 ? ptsel_pkg::scan_tilt(scan_idx_q) : sel_tilt_s2;
			source_q   <= ~emit_scan_s2;
		end
	end

	// pipeline control and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			aim_valid_q <= 1'b0;
			cur_pan_q   <= '0;
			cur_tilt_q  <= '0;
			scan_idx_q  <= ptsel_pkg::SCAN_START;
			best_pan_q  <= '0;
			best_tilt_q <= '0;
			best_dist_q <= '0;
			has_best_q  <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= item_valid;
			end
			if (free_s2) begin
				v_s2 <= go_s1;
			end

			if (go_s2 && emit_s2) begin
				aim_valid_q <= 1'b1;
			end else if (aim_ready) begin
				aim_valid_q <= 1'b0;
			end

			if (go_s1 && (cmd_s1 == ptsel_pkg::CMD_POSE)) begin
				cur_pan_q  <= pan_s1;
				cur_tilt_q <= tilt_s1;
			end

			if (go_s2) begin
				if (emit_scan_s2) begin
					scan_idx_q <= ptsel_pkg::scan_next(scan_idx_q);
				end
				case (cmd_s2)
					ptsel_pkg::CMD_EMPTY: begin
						best_pan_q  <= '0;
						best_tilt_q <= '0;
						best_dist_q <= '0;
						has_best_q  <= 1'b0;
					end
					ptsel_pkg::CMD_TARGET: begin
						if (last_s2) begin
							best_pan_q  <= '0;
							best_tilt_q <= '0;
							best_dist_q <= '0;
							has_best_q  <= 1'b0;
						end else if (better_s2) begin
							best_pan_q  <= pan_s2;
							best_tilt_q <= tilt_s2;
							best_dist_q <= dist_s2;
							has_best_q  <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign aim_valid = aim_valid_q;
	assign aim_pan   = aim_pan_q;
	assign aim_tilt  = aim_tilt_q;
	assign source    = source_q;

endmodule

[rtl/core/ptsel_checker.sv]
module ptsel_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 psel,
	input logic                                 penable,
	input logic                                 pwrite,
	input logic [ptsel_pkg::PADDR_W-1:0]        paddr,
	input logic [ptsel_pkg::PDATA_W-1:0]        pwdata,
	input logic [ptsel_pkg::PDATA_W-1:0]        prdata,
	input logic                                 pready,
	input logic                                 item_valid,
	input logic                                 item_ready,
	input logic [ptsel_pkg::CMD_W-1:0]          command,
	input logic signed [ptsel_pkg::PAN_W-1:0]   pan,
	input logic signed [ptsel_pkg::TILT_W-1:0]  tilt,
	input logic                                 last,
	input logic                                 aim_valid,
	input logic                                 aim_ready,
	input logic signed [ptsel_pkg::PAN_W-1:0]   aim_pan,
	input logic signed [ptsel_pkg::TILT_W-1:0]  aim_tilt,
	input logic                                 source
);

	// a stalled aim transaction holds
	a_aim_hold: assert property (@(posedge clk) disable iff (!arst_n)
		aim_valid && !aim_ready |=> aim_valid && $stable(aim_pan) && $stable(aim_tilt)
			&& $stable(source))
		else $error("aim transaction changed while stalled");

	// scan aims are table positions, pan and tilt from the same entry
	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		aim_valid && !source |->
			((aim_pan == 15'sd0 || aim_pan == 15'sd3200)
				&& (aim_tilt == -14'sd1280 || aim_tilt == -14'sd3200))
			|| (aim_pan == 15'sd1600 && aim_tilt == -14'sd2240))
		else $error("scan aim is not a scan position");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready && prdata[ptsel_pkg::PDATA_W-1:ptsel_pkg::MODE_W] == '0)
		else $error("APB ready low or unused read bits set");

	// mode readback follows a completed write
	a_mode_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == ptsel_pkg::REG_MODE) |=>
			(paddr[2] != ptsel_pkg::REG_MODE)
			|| (prdata[ptsel_pkg::MODE_W-1:0] == $past(pwdata[ptsel_pkg::MODE_W-1:0])))
		else $error("mode readback differs from written value");

endmodule

bind pan_tilt_scan_track_selector ptsel_checker u_ptsel_checker (.*);
